// ===== src/clw_pkg.sv =====
package clw_pkg;

    // display geometry
    localparam int ROWS      = 4;
    localparam int COLS      = 20;
    localparam int CHAR_CAP  = ROWS * COLS;

    // longest burst of bus writes for one transaction (the init sequence)
    localparam int INIT_LEN  = 7;
    localparam int CNT_W     = 3;

    // request modes
    localparam logic [1:0] MODE_INIT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_SCREEN = 2'd2;
    localparam logic [1:0] MODE_LINE   = 2'd3;

    // character codes and commands
    localparam logic [7:0] CH_END      = 8'h00;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CMD_CLEAR   = 8'h01;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] text_char;
        logic       first_char;
        logic [1:0] start_row;
        logic [4:0] start_col;
    } item_t;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       is_data;
        logic       last;
    } bus_wr_t;

    // one queued bus write
    typedef struct packed {
        logic [7:0] code;
        logic       is_data;
    } wr_t;

    typedef struct packed {
        logic [1:0] row;
        logic [4:0] col;
        logic [6:0] taken;
        logic       stopped;
    } lcd_state_t;

    typedef struct packed {
        wr_t [INIT_LEN-1:0] w;
        logic [CNT_W-1:0]   cnt;
        lcd_state_t         nxt;
    } plan_t;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] b;
        unique case (row)
            2'd0: b = 8'h80;
            2'd1: b = 8'hC0;
            2'd2: b = 8'h94;
            2'd3: b = 8'hD4;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] init_byte(input logic [CNT_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0, 3'd1, 3'd2: b = 8'h30;
            3'd3:             b = 8'h3C;
            3'd4:             b = 8'h0C;
            3'd5:             b = 8'h01;
            default:          b = 8'h06;
        endcase
        return b;
    endfunction

    function automatic wr_t set_addr(input logic [1:0] row, input logic [4:0] col);
        wr_t r;
        r.code    = row_base(row) + {3'b000, col};
        r.is_data = 1'b0;
        return r;
    endfunction

endpackage

// ===== src/clw_planner.sv =====
module clw_planner
    import clw_pkg::*;
(
    input  item_t      item,
    input  lcd_state_t cur,
    output plan_t      plan
);

    lcd_state_t         st;
    wr_t [INIT_LEN-1:0] w;
    logic [CNT_W-1:0]   n;
    logic               go;
    logic               pos;

    always_comb
    begin
        st  = cur;
        w   = '0;
        n   = '0;
        go  = 1'b0;
        pos = (item.mode == MODE_LINE);

        unique case (item.mode)
            MODE_INIT:
            begin
                for (int i = 0; i < INIT_LEN; i++)
                begin
                    w[i].code    = init_byte(CNT_W'(i));
                    w[i].is_data = 1'b0;
                end
                n      = CNT_W'(INIT_LEN);
                st.row = '0;
                st.col = '0;
            end
            MODE_CLEAR:
            begin
                w[0].code    = CMD_CLEAR;
                w[0].is_data = 1'b0;
                n            = CNT_W'(1);
                st.row       = '0;
                st.col       = '0;
            end
            MODE_SCREEN:
            begin
                if (item.first_char)
                begin
                    w[0].code    = CMD_CLEAR;
                    w[0].is_data = 1'b0;
                    n            = CNT_W'(1);
                    st.row       = '0;
                    st.col       = '0;
                    st.taken     = '0;
                    st.stopped   = 1'b0;
                end
                go = !st.stopped;
            end
            MODE_LINE:
            begin
                if (item.first_char)
                begin
                    if (int'(item.start_row) < ROWS && int'(item.start_col) < COLS)
                    begin
                        w[0]       = set_addr(item.start_row, item.start_col);
                        n          = CNT_W'(1);
                        st.row     = item.start_row;
                        st.col     = item.start_col;
                        st.stopped = 1'b0;
                    end
                    else
                    begin
                        st.stopped = 1'b1;
                    end
                end
                go = !st.stopped;
            end
        endcase

        // one character of a string
        if (go)
        begin
            if (item.text_char == CH_END)
            begin
                st.stopped = 1'b1;
            end
            else if (pos || int'(st.taken) < CHAR_CAP)
            begin
                if (!pos)
                    st.taken = st.taken + 7'd1;
                if (item.text_char == CH_NEWLINE)
                begin
                    if (int'(st.row) + 1 < ROWS)
                    begin
                        w[n]   = set_addr(st.row + 2'd1, 5'd0);
                        n      = n + CNT_W'(1);
                        st.row = st.row + 2'd1;
                        st.col = '0;
                        if (pos)
                            st.stopped = 1'b1;
                    end
                    else
                    begin
                        st.stopped = 1'b1;
                    end
                end
                else if (int'(st.col) + 1 < COLS)
                begin
                    w[n].code    = item.text_char;
                    w[n].is_data = 1'b1;
                    n            = n + CNT_W'(1);
                    w[n]         = set_addr(st.row, st.col + 5'd1);
                    n            = n + CNT_W'(1);
                    st.col       = st.col + 5'd1;
                end
                else if (int'(st.col) + 1 == COLS)
                begin
                    w[n].code    = item.text_char;
                    w[n].is_data = 1'b1;
                    n            = n + CNT_W'(1);
                    if (pos)
                        st.stopped = 1'b1;
                end
                else if (pos)
                begin
                    st.stopped = 1'b1;
                end
            end
        end

        plan.w   = w;
        plan.cnt = n;
        plan.nxt = st;
    end

endmodule

// ===== src/char_lcd_text_writer.sv =====
// Character LCD text writer for a 4 x 20 HD44780-style display. Each request
// transaction (init, clear, or one character of a whole-screen or positioned
// string) turns into zero to seven 8-bit bus write transactions, each tagged
// command or data, with last set on the final write of the request. A request
// is registered, planned in one pass against the tracked cursor, and its
// writes are queued; the bus side then delivers one write per cycle while
// bus_stall is low. A clear is one write, a printable character one to
// three, init seven; an ignored character writes nothing. The single write
// port is what sets the rate. An accepted request sits in the input register
// and its writes in the queue before the first goes out. The next request is
// planned in the same cycle that the previous request's last write is taken.
module char_lcd_text_writer
    import clw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,

    // request channel
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,

    // bus write channel
    output logic    bus_valid,
    input  logic    bus_stall,
    output bus_wr_t bus_wr
);

    // input register
    item_t              in_reg;
    logic               in_vld_reg;

    // cursor and string tracking
    lcd_state_t         st_reg;

    // queue of planned bus writes for the current request
    wr_t [INIT_LEN-1:0] q_reg;
    logic [CNT_W-1:0]   q_cnt_reg;
    logic [CNT_W-1:0]   q_idx_reg;
    logic               q_vld_reg;

    plan_t              plan;
    logic               is_last;
    logic               out_take;
    logic               q_free;
    logic               load;

    clw_planner u_planner
    (
        .item (in_reg),
        .cur  (st_reg),
        .plan (plan)
    );

    assign is_last  = (q_idx_reg == q_cnt_reg - CNT_W'(1));
    assign out_take = q_vld_reg & ~bus_stall;
    // queue can take a new plan when empty or when its last write leaves now
    assign q_free   = ~q_vld_reg | (out_take & is_last);
    assign load     = in_vld_reg & q_free;

    // the input register frees up whenever its request gets planned
    assign item_stall = in_vld_reg & ~load;

    assign bus_valid        = q_vld_reg;
    assign bus_wr.bus_byte  = q_reg[q_idx_reg].code;
    assign bus_wr.is_data   = q_reg[q_idx_reg].is_data;
    assign bus_wr.last      = is_last;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            st_reg     <= '0;
            q_cnt_reg  <= '0;
            q_idx_reg  <= '0;
            q_vld_reg  <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
                in_vld_reg <= 1'b1;
            else if (load)
                in_vld_reg <= 1'b0;

            if (load)
                st_reg <= plan.nxt;

            // a request that writes nothing leaves the queue alone
            if (load && plan.cnt != '0)
            begin
                q_cnt_reg <= plan.cnt;
                q_idx_reg <= '0;
                q_vld_reg <= 1'b1;
            end
            else if (out_take)
            begin
                if (is_last)
                    q_vld_reg <= 1'b0;
                else
                    q_idx_reg <= q_idx_reg + CNT_W'(1);
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            in_reg <= item;
        if (load && plan.cnt != '0)
            q_reg <= plan.w;
    end

endmodule
